>>> hdl/light_trend_day_phase_detector_top_defines.svh
// Assertion macros shared by the day phase detector RTL.
// Every macro assumes the module has a clock clk and a synchronous reset rst.
`ifndef LIGHT_TREND_DAY_PHASE_DETECTOR_TOP_DEFINES_SVH
`define LIGHT_TREND_DAY_PHASE_DETECTOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LTDP_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LTDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> hdl/ltdp_pkg.sv
// Package for the day phase detector: sizes, constants, codes and the fit sums type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ltdp_pkg;

  localparam int DEPTH      = 30;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int NV_W       = $clog2(DEPTH + 1);
  localparam int LUX_W      = 21;
  localparam int STAMP_W    = 32;
  localparam int SUM_W      = 33;
  localparam int CNT_W      = 12;
  localparam int LVL_W      = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam int COUNT_MAX  = 4095;
  localparam int FIRST_PUSH = 10;
  localparam int MIN_POINTS = 5;
  localparam int MINUTE_MS  = 60000;
  localparam int MAX_AGE    = DEPTH * MINUTE_MS + 5000;
  localparam int T_W        = $clog2(MAX_AGE + 1);
  localparam longint K_TEN  = 64'(10) * 64'(DEPTH - 1) * 64'(MINUTE_MS);

  localparam int ST_W  = T_W + NV_W;
  localparam int SL_W  = LUX_W + NV_W;
  localparam int ST2_W = 2 * T_W + NV_W;
  localparam int STL_W = T_W + LUX_W + NV_W;

  // Shared multiplier: 64 by 64 bits, one 16-bit digit of b per cycle.
  localparam int OP_W   = 64;
  localparam int PR_W   = 128;
  localparam int DIG_W  = 16;
  localparam int DIGITS = OP_W / DIG_W;

  localparam logic [1:0] PH_UNKNOWN = 2'd0;
  localparam logic [1:0] PH_DAY     = 2'd1;
  localparam logic [1:0] PH_NIGHT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUNRISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUNSET  = 2'd2;

  typedef struct packed {
    logic [NV_W-1:0]  n;
    logic [ST_W-1:0]  st;
    logic [SL_W-1:0]  sl;
    logic [ST2_W-1:0] st2;
    logic [STL_W-1:0] stl;
  } fit_sums_t;

endpackage
`default_nettype wire

>>> hdl/ltdp_if.sv
// Valid/ready channel interfaces for readings in and phase results out.
// Depends on ltdp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface ltdp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        reading_ok;
  logic [ltdp_pkg::LUX_W-1:0]  lux;
  logic [ltdp_pkg::STAMP_W-1:0] now_ms;
  modport source (output valid, reading_ok, lux, now_ms, input ready);
  modport sink (input valid, reading_ok, lux, now_ms, output ready);
endinterface

interface ltdp_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 day_phase;
  logic                       sample_pushed;
  logic                       fit_done;
  logic [ltdp_pkg::LUX_W-1:0] minute_average;
  modport source (output valid, day_phase, sample_pushed, fit_done, minute_average,
                  input ready);
  modport sink (input valid, day_phase, sample_pushed, fit_done, minute_average,
                output ready);
endinterface
`default_nettype wire

>>> hdl/light_trend_day_phase_detector_top.sv
// Top level of the day phase detector: configuration, reading accumulation,
// fit sequencing and the result register. Depends on ltdp_pkg, ltdp_if,
// ltdp_div, ltdp_mul, ltdp_win and the assertion macro header.
//
// A reading that pushes no minute average goes from acceptance through the
// finishing state into the result register. A reading that pushes also runs
// the serial divider, a walk of the window memory one entry per cycle, and,
// when enough points took part, up to nine products on the one shared
// multiplier, built from 64 x 16 partial products, then four compares and the
// phase update. One reading is handled at a time; the next is accepted while
// a finished result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "light_trend_day_phase_detector_top_defines.svh"
module light_trend_day_phase_detector_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [ltdp_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [ltdp_pkg::CFG_DATA_W-1:0]     wr_data,
  ltdp_in_if.sink                             in_ch,
  ltdp_out_if.source                          out_ch
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_PH   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam logic [3:0] MS_NST2 = 4'd0;
  localparam logic [3:0] MS_SST  = 4'd1;
  localparam logic [3:0] MS_NPOS = 4'd2;
  localparam logic [3:0] MS_NNEG = 4'd3;
  localparam logic [3:0] MS_OPOS = 4'd4;
  localparam logic [3:0] MS_STSL = 4'd5;
  localparam logic [3:0] MS_ONEG = 4'd6;
  localparam logic [3:0] MS_RISE = 4'd7;
  localparam logic [3:0] MS_SET  = 4'd8;

  localparam logic [1:0] CMP_NOW_RISE = 2'd0;
  localparam logic [1:0] CMP_OLD_RISE = 2'd1;
  localparam logic [1:0] CMP_NOW_SET  = 2'd2;
  localparam logic [1:0] CMP_OLD_SET  = 2'd3;

  localparam int SUM_W = ltdp_pkg::SUM_W;
  localparam int CNT_W = ltdp_pkg::CNT_W;
  localparam int LUX_W = ltdp_pkg::LUX_W;
  localparam int OP_W  = ltdp_pkg::OP_W;
  localparam int PR_W  = ltdp_pkg::PR_W;

  // Configuration
  logic                       tracker_enable;
  logic [ltdp_pkg::LVL_W-1:0] sunrise_level;
  logic [ltdp_pkg::LVL_W-1:0] sunset_level;

  logic [2:0]                   state;
  logic [SUM_W-1:0]             reading_sum;
  logic [CNT_W-1:0]             reading_count;
  logic [1:0]                   phase;
  logic [ltdp_pkg::STAMP_W-1:0] now_r;
  logic                         pushed_r;
  logic                         fitted_r;
  logic [LUX_W-1:0]             avg_r;

  logic             accept;
  logic             active;
  logic [SUM_W-1:0] sum_upd;
  logic [CNT_W-1:0] cnt_upd;
  logic             push_dec;

  logic             div_done;
  logic [SUM_W-1:0] quotient;

  logic                         win_push;
  logic                         has_entry;
  logic [ltdp_pkg::STAMP_W-1:0] newest_stamp;
  logic                         walk_done;
  ltdp_pkg::fit_sums_t          sums;

  logic            mul_go;
  logic            mul_go_next;
  logic [3:0]      mstep;
  logic [OP_W-1:0] op_a, op_b;
  logic            mul_done;
  logic [PR_W-1:0] prod;
  logic [OP_W-1:0] nst2, dval, d_next, stsl;
  logic [PR_W-1:0] now_pos, now_neg, old_pos, old_neg, rise, set_lvl;

  logic [1:0]      cc;
  logic [3:0]      flags;
  logic [PR_W-1:0] cmp_x, cmp_y1, cmp_y2, cmp_y;
  logic            cmp_gt;

  logic out_free;

  assign in_ch.ready = state == S_IDLE;
  assign accept      = in_ch.valid && in_ch.ready;
  assign active      = in_ch.reading_ok && tracker_enable;
  assign out_free    = !out_ch.valid || out_ch.ready;

  // Saturated count stops both counting and summing until the next push.
  always_comb begin
    if (reading_count < CNT_W'(ltdp_pkg::COUNT_MAX)) begin
      sum_upd = reading_sum + SUM_W'(in_ch.lux);
      cnt_upd = reading_count + 1'b1;
    end else begin
      sum_upd = reading_sum;
      cnt_upd = reading_count;
    end
    if (!has_entry) begin
      push_dec = cnt_upd > CNT_W'(ltdp_pkg::FIRST_PUSH);
    end else begin
      push_dec = (in_ch.now_ms - newest_stamp) >= ltdp_pkg::STAMP_W'(ltdp_pkg::MINUTE_MS);
    end
  end

  assign win_push = state == S_DIV && div_done;
  assign d_next   = nst2 - prod[OP_W-1:0];

  // A product is started after the walk when enough points took part, and
  // after each product but the last unless the fit turned out degenerate.
  assign mul_go_next = (state == S_WALK && walk_done
                        && sums.n >= ltdp_pkg::NV_W'(ltdp_pkg::MIN_POINTS))
                     || (state == S_MUL && mul_done && mstep != MS_SET
                         && !(mstep == MS_SST && d_next == '0));

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (mstep)
      MS_NST2: begin
        op_a = OP_W'(sums.n);
        op_b = OP_W'(sums.st2);
      end
      MS_SST: begin
        op_a = OP_W'(sums.st);
        op_b = OP_W'(sums.st);
      end
      MS_NPOS: begin
        op_a = OP_W'(sums.sl) * OP_W'(10);
        op_b = OP_W'(sums.st2);
      end
      MS_NNEG: begin
        op_a = OP_W'(sums.st) * OP_W'(10);
        op_b = OP_W'(sums.stl);
      end
      MS_OPOS: begin
        op_a = OP_W'(ltdp_pkg::K_TEN) * OP_W'(sums.n);
        op_b = OP_W'(sums.stl);
      end
      MS_STSL: begin
        op_a = OP_W'(sums.st);
        op_b = OP_W'(sums.sl);
      end
      MS_ONEG: begin
        op_a = OP_W'(ltdp_pkg::K_TEN);
        op_b = stsl;
      end
      MS_RISE: begin
        op_a = OP_W'({sunrise_level, 4'b0000});
        op_b = dval;
      end
      MS_SET: begin
        op_a = OP_W'({sunset_level, 4'b0000});
        op_b = dval;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // One shared add and compare per cycle; a trigger level scaled by D sits on
  // the side of the inequality that needs it.
  always_comb begin
    unique case (cc)
      CMP_NOW_RISE: begin
        cmp_x  = now_pos;
        cmp_y1 = now_neg;
        cmp_y2 = rise;
      end
      CMP_OLD_RISE: begin
        cmp_x  = old_pos;
        cmp_y1 = old_neg;
        cmp_y2 = rise;
      end
      CMP_NOW_SET: begin
        cmp_x  = now_pos;
        cmp_y1 = now_neg;
        cmp_y2 = set_lvl;
      end
      CMP_OLD_SET: begin
        cmp_x  = old_pos;
        cmp_y1 = old_neg;
        cmp_y2 = set_lvl;
      end
      default: begin
        cmp_x  = '0;
        cmp_y1 = '0;
        cmp_y2 = '0;
      end
    endcase
    cmp_y  = cmp_y1 + cmp_y2;
    cmp_gt = (cc == CMP_NOW_RISE || cc == CMP_OLD_SET) ? (cmp_x > cmp_y) : (cmp_y > cmp_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracker_enable <= 1'b0;
      sunrise_level  <= ltdp_pkg::LVL_W'(100);
      sunset_level   <= ltdp_pkg::LVL_W'(50);
    end else if (wr_en) begin
      unique case (wr_index)
        ltdp_pkg::REG_ENABLE:  tracker_enable <= wr_data[0];
        ltdp_pkg::REG_SUNRISE: sunrise_level  <= wr_data;
        ltdp_pkg::REG_SUNSET:  sunset_level   <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      reading_sum   <= '0;
      reading_count <= '0;
      phase         <= ltdp_pkg::PH_UNKNOWN;
      out_ch.valid  <= 1'b0;
      mul_go        <= 1'b0;
      mstep         <= MS_NST2;
      cc            <= CMP_NOW_RISE;
    end else begin
      mul_go <= mul_go_next;
      if (state == S_FIN && out_free) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (active) begin
              reading_sum   <= sum_upd;
              reading_count <= cnt_upd;
              state         <= push_dec ? S_DIV : S_FIN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            reading_sum   <= '0;
            reading_count <= '0;
            state         <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_done) begin
            if (sums.n < ltdp_pkg::NV_W'(ltdp_pkg::MIN_POINTS)) begin
              state <= S_FIN;
            end else begin
              mstep <= MS_NST2;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            if (mstep == MS_SST && d_next == '0) begin
              // All ages equal: the fit counts as run but the phase holds.
              state <= S_FIN;
            end else if (mstep == MS_SET) begin
              cc    <= CMP_NOW_RISE;
              state <= S_CMP;
            end else begin
              mstep <= mstep + 1'b1;
            end
          end
        end
        S_CMP: begin
          cc <= cc + 1'b1;
          if (cc == CMP_OLD_SET) begin
            state <= S_PH;
          end
        end
        S_PH: begin
          if (phase != ltdp_pkg::PH_DAY && flags[CMP_OLD_RISE] && flags[CMP_NOW_RISE]) begin
            phase <= ltdp_pkg::PH_DAY;
          end else if (phase != ltdp_pkg::PH_NIGHT && flags[CMP_OLD_SET]
                       && flags[CMP_NOW_SET]) begin
            phase <= ltdp_pkg::PH_NIGHT;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r    <= in_ch.now_ms;
      pushed_r <= 1'b0;
      fitted_r <= 1'b0;
      avg_r    <= '0;
    end
    if (win_push) begin
      pushed_r <= 1'b1;
      avg_r    <= quotient[LUX_W-1:0];
    end
    if (state == S_WALK && walk_done
        && sums.n >= ltdp_pkg::NV_W'(ltdp_pkg::MIN_POINTS)) begin
      fitted_r <= 1'b1;
    end
    if (state == S_MUL && mul_done) begin
      case (mstep)
        MS_NST2: nst2    <= prod[OP_W-1:0];
        MS_SST:  dval    <= d_next;
        MS_NPOS: now_pos <= prod;
        MS_NNEG: now_neg <= prod;
        MS_OPOS: old_pos <= now_pos + prod;
        MS_STSL: stsl    <= prod[OP_W-1:0];
        MS_ONEG: old_neg <= now_neg + prod;
        MS_RISE: rise    <= prod;
        MS_SET:  set_lvl <= prod;
        default: ;
      endcase
    end
    if (state == S_CMP) begin
      flags[cc] <= cmp_gt;
    end
    if (state == S_FIN && out_free) begin
      out_ch.day_phase      <= phase;
      out_ch.sample_pushed  <= pushed_r;
      out_ch.fit_done       <= fitted_r;
      out_ch.minute_average <= avg_r;
    end
  end

  ltdp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && active && push_dec),
    .dividend (sum_upd),
    .divisor  (cnt_upd),
    .done     (div_done),
    .quotient (quotient)
  );

  ltdp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_go),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .p     (prod)
  );

  ltdp_win u_win (
    .clk          (clk),
    .rst          (rst),
    .push         (win_push),
    .push_level   (quotient[LUX_W-1:0]),
    .push_stamp   (now_r),
    .has_entry    (has_entry),
    .newest_stamp (newest_stamp),
    .walk_done    (walk_done),
    .sums         (sums)
  );

  `LTDP_ASSERT(top_idle_fields, out_ch.valid && !out_ch.sample_pushed, !out_ch.fit_done && out_ch.minute_average == '0)
  `LTDP_ASSERT_NEXT(top_push_clears, win_push, reading_count == '0 && reading_sum == '0)
  `LTDP_ASSERT(top_fit_needs_push, state == S_FIN && fitted_r, pushed_r)
endmodule
`default_nettype wire

>>> hdl/ltdp_div.sv
// Restoring divider, one quotient bit per cycle, for the minute average.
// Depends on ltdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ltdp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ltdp_pkg::SUM_W-1:0] dividend,
  input  logic [ltdp_pkg::CNT_W-1:0] divisor,
  output logic                       done,
  output logic [ltdp_pkg::SUM_W-1:0] quotient
);
  localparam int STEP_W = $clog2(ltdp_pkg::SUM_W + 1);

  logic                       busy;
  logic [STEP_W-1:0]          step;
  logic [ltdp_pkg::CNT_W-1:0] rem;
  logic [ltdp_pkg::CNT_W-1:0] dvs;
  logic [ltdp_pkg::CNT_W:0]   rem_sh;
  logic                       fits;

  assign rem_sh = {rem, quotient[ltdp_pkg::SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !start && busy && (step == STEP_W'(ltdp_pkg::SUM_W - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(ltdp_pkg::SUM_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= ltdp_pkg::CNT_W'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= rem_sh[ltdp_pkg::CNT_W-1:0];
      end
      quotient <= {quotient[ltdp_pkg::SUM_W-2:0], fits};
    end
  end
endmodule
`default_nettype wire

>>> hdl/ltdp_mul.sv
// Shared multi-cycle multiplier: 64 x 64 bits as four 64 x 16 partial products.
// Depends on ltdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ltdp_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ltdp_pkg::OP_W-1:0] a,
  input  logic [ltdp_pkg::OP_W-1:0] b,
  output logic                      done,
  output logic [ltdp_pkg::PR_W-1:0] p
);
  localparam int STEP_W = $clog2(ltdp_pkg::DIGITS + 1);
  localparam int PART_W = ltdp_pkg::OP_W + ltdp_pkg::DIG_W;

  logic                      busy;
  logic [STEP_W-1:0]         step;
  logic [ltdp_pkg::OP_W-1:0] a_r;
  logic [ltdp_pkg::OP_W-1:0] b_sh;
  logic [PART_W-1:0]         part;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !start && busy && (step == STEP_W'(ltdp_pkg::DIGITS));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(ltdp_pkg::DIGITS)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Lowest digit first; the accumulator shifts right one digit per add so
  // that each partial product lands at its own weight.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_sh <= b;
      p    <= '0;
    end else if (busy) begin
      part <= a_r * b_sh[ltdp_pkg::DIG_W-1:0];
      b_sh <= b_sh >> ltdp_pkg::DIG_W;
      if (step != '0) begin
        p <= (p >> ltdp_pkg::DIG_W)
           + {part, {(ltdp_pkg::PR_W - PART_W){1'b0}}};
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/ltdp_win.sv
// Window of minute averages in a circular memory, and the walk that sums it for the fit.
// Depends on ltdp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "light_trend_day_phase_detector_top_defines.svh"
module ltdp_win (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [ltdp_pkg::LUX_W-1:0]   push_level,
  input  logic [ltdp_pkg::STAMP_W-1:0] push_stamp,
  output logic                         has_entry,
  output logic [ltdp_pkg::STAMP_W-1:0] newest_stamp,
  output logic                         walk_done,
  output ltdp_pkg::fit_sums_t          sums
);
  localparam int IDX_W  = ltdp_pkg::IDX_W;
  localparam int NV_W   = ltdp_pkg::NV_W;
  localparam int WORD_W = ltdp_pkg::LUX_W + ltdp_pkg::STAMP_W;
  localparam int T_W    = ltdp_pkg::T_W;

  logic [WORD_W-1:0] mem [ltdp_pkg::DEPTH];

  logic [IDX_W-1:0]             head;
  logic [IDX_W-1:0]             head_dec;
  logic [NV_W-1:0]              nvalid;
  logic [NV_W-1:0]              nvalid_inc;
  logic [ltdp_pkg::STAMP_W-1:0] now_r;
  logic                         busy;
  logic [IDX_W-1:0]             rptr;
  logic [NV_W-1:0]              left;
  logic                         v1, v2, v3;
  logic [WORD_W-1:0]            rd_word;
  logic [ltdp_pkg::STAMP_W-1:0] age;
  logic [T_W-1:0]               t1, t2;
  logic [ltdp_pkg::LUX_W-1:0]   l1, l2;
  logic                         u1, u2;
  logic [ltdp_pkg::ST2_W-1:0]   tt;
  logic [ltdp_pkg::STL_W-1:0]   tl;

  // The newest entry sits at the head: a push steps the head back instead of shifting.
  assign head_dec   = (head == '0) ? IDX_W'(ltdp_pkg::DEPTH - 1) : head - 1'b1;
  assign nvalid_inc = (nvalid == NV_W'(ltdp_pkg::DEPTH)) ? nvalid : nvalid + 1'b1;
  assign has_entry  = nvalid != '0;
  assign age        = now_r - rd_word[ltdp_pkg::STAMP_W-1:0];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[head_dec] <= {push_level, push_stamp};
    end
    if (busy && left != '0) begin
      rd_word <= mem[rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      nvalid    <= '0;
      busy      <= 1'b0;
      left      <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      walk_done <= 1'b0;
    end else begin
      walk_done <= !push && busy && left == '0 && !v1 && !v2 && !v3;
      v1 <= busy && left != '0;
      v2 <= v1;
      v3 <= v2;
      if (push) begin
        head   <= head_dec;
        nvalid <= nvalid_inc;
        busy   <= 1'b1;
        left   <= nvalid_inc;
      end else if (busy) begin
        if (left != '0) begin
          left <= left - 1'b1;
        end else if (!v1 && !v2 && !v3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      newest_stamp <= push_stamp;
      now_r        <= push_stamp;
      rptr         <= head_dec;
      sums         <= '0;
    end else begin
      if (busy && left != '0) begin
        rptr <= (rptr == IDX_W'(ltdp_pkg::DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      // Entries stamped later than now wrap to a huge age and drop out here.
      t1 <= age[T_W-1:0];
      l1 <= rd_word[WORD_W-1:ltdp_pkg::STAMP_W];
      u1 <= age <= ltdp_pkg::STAMP_W'(ltdp_pkg::MAX_AGE);
      tt <= ltdp_pkg::ST2_W'(t1 * t1);
      tl <= ltdp_pkg::STL_W'(t1 * l1);
      t2 <= t1;
      l2 <= l1;
      u2 <= u1;
      if (v3 && u2) begin
        sums.n   <= sums.n + 1'b1;
        sums.st  <= sums.st + ltdp_pkg::ST_W'(t2);
        sums.sl  <= sums.sl + ltdp_pkg::SL_W'(l2);
        sums.st2 <= sums.st2 + tt;
        sums.stl <= sums.stl + tl;
      end
    end
  end

  `LTDP_ASSERT(win_nvalid_bound, 1'b1, nvalid <= NV_W'(ltdp_pkg::DEPTH))
  `LTDP_ASSERT(win_push_when_idle, push, !busy)
  `LTDP_ASSERT(win_done_drained, walk_done, !busy && !v3 && left == '0)
endmodule
`default_nettype wire

>>> tb/ltdp_phase_checker.sv
// Checker for the day phase detector: watches the register port and both channels,
// predicts every result beat and compares it field by field.
// Depends on ltdp_pkg and ltdp_if.
`timescale 1ns / 1ps
module ltdp_phase_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [ltdp_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [ltdp_pkg::CFG_DATA_W-1:0] wr_data,
  ltdp_in_if                              in_ch,
  ltdp_out_if                             out_ch,
  output int                              fails,
  output int                              pending
);
  import ltdp_pkg::*;

  typedef struct {
    logic [1:0]       phase;
    logic             pushed;
    logic             fitted;
    logic [LUX_W-1:0] avg;
  } phase_result_t;

  phase_result_t      result_queue[$];
  logic [LUX_W-1:0]   win_level[DEPTH];
  logic [STAMP_W-1:0] win_stamp[DEPTH];
  logic               win_valid[DEPTH];
  logic [SUM_W-1:0]   lux_sum;
  logic [CNT_W-1:0]   lux_count;
  logic [1:0]         phase_q;
  logic               enable_q;
  logic [LVL_W-1:0]   rise_q;
  logic [LVL_W-1:0]   set_q;

  task automatic report(string field, longint got, longint want);
    $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, want);
    fails++;
  endtask

  // Exact least-squares trend over the window, with the triggers compared
  // without rounding. Returns whether enough points took part.
  function automatic logic fit_window(input logic [STAMP_W-1:0] now);
    logic [STAMP_W-1:0] age32;
    logic [255:0] n, st, sl, st2, stl, t, d, np, nn, op, on, rise, sett;
    logic above_now, below_old, below_now, above_old;
    n = 0; st = 0; sl = 0; st2 = 0; stl = 0;
    for (int i = 0; i < DEPTH; i++) begin
      age32 = now - win_stamp[i];
      t = 256'(age32);
      if (win_valid[i] && t <= 256'(MAX_AGE)) begin
        st  += t;
        sl  += 256'(win_level[i]);
        st2 += t * t;
        stl += t * 256'(win_level[i]);
        n   += 1;
      end
    end
    if (n < MIN_POINTS) return 1'b0;
    d = n * st2 - st * st;
    if (d == 0) return 1'b1;
    np   = 10 * sl * st2;
    nn   = 10 * st * stl;
    op   = np + 10 * 256'(DEPTH - 1) * 256'(MINUTE_MS) * n * stl;
    on   = nn + 10 * 256'(DEPTH - 1) * 256'(MINUTE_MS) * st * sl;
    rise = 16 * 256'(rise_q) * d;
    sett = 16 * 256'(set_q) * d;
    above_now = np > nn + rise;
    below_old = on + rise > op;
    below_now = nn + sett > np;
    above_old = op > on + sett;
    if (phase_q != PH_DAY && below_old && above_now) phase_q = PH_DAY;
    else if (phase_q != PH_NIGHT && above_old && below_now) phase_q = PH_NIGHT;
    return 1'b1;
  endfunction

  function automatic phase_result_t predict_reading(input logic ok, input logic [LUX_W-1:0] lux,
                                                    input logic [STAMP_W-1:0] now);
    phase_result_t r;
    logic do_push;
    logic [STAMP_W-1:0] since;
    r.pushed = 0; r.fitted = 0; r.avg = 0;
    if (ok && enable_q) begin
      if (lux_count < CNT_W'(COUNT_MAX)) begin
        lux_sum   += SUM_W'(lux);
        lux_count += 1;
      end
      since = now - win_stamp[0];
      do_push = win_valid[0] ? (since >= STAMP_W'(MINUTE_MS)) : (lux_count > CNT_W'(FIRST_PUSH));
      if (do_push) begin
        for (int i = DEPTH - 1; i > 0; i--) begin
          win_level[i] = win_level[i-1];
          win_stamp[i] = win_stamp[i-1];
          win_valid[i] = win_valid[i-1];
        end
        r.avg = LUX_W'(lux_sum / SUM_W'(lux_count));
        win_level[0] = r.avg;
        win_stamp[0] = now;
        win_valid[0] = 1'b1;
        r.pushed = 1'b1;
        r.fitted = fit_window(now);
        lux_sum   = 0;
        lux_count = 0;
      end
    end
    r.phase = phase_q;
    return r;
  endfunction

  // Everything is sampled at the falling edge, clear of the rising edge at
  // which the beats and writes take effect.
  always @(negedge clk) begin
    phase_result_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        win_valid[i] = 0; win_level[i] = 0; win_stamp[i] = 0;
      end
      lux_sum = 0; lux_count = 0; phase_q = PH_UNKNOWN;
      enable_q = 0; rise_q = 100; set_q = 50;
      result_queue.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_ENABLE:  enable_q = wr_data[0];
          REG_SUNRISE: rise_q = wr_data;
          REG_SUNSET:  set_q = wr_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        result_queue.push_back(predict_reading(in_ch.reading_ok, in_ch.lux, in_ch.now_ms));
      if (out_ch.valid && out_ch.ready) begin
        if (result_queue.size() == 0) begin
          $display("%0t ns: result beat with nothing outstanding", $time);
          fails++;
        end else begin
          want = result_queue.pop_front();
          if (out_ch.day_phase !== want.phase)
            report("day_phase", out_ch.day_phase, want.phase);
          if (out_ch.sample_pushed !== want.pushed)
            report("sample_pushed", out_ch.sample_pushed, want.pushed);
          if (out_ch.fit_done !== want.fitted)
            report("fit_done", out_ch.fit_done, want.fitted);
          if (out_ch.minute_average !== want.avg)
            report("minute_average", out_ch.minute_average, want.avg);
        end
      end
    end
    pending = result_queue.size();
  end

  initial fails = 0;

endmodule

>>> tb/tb.sv
// Testbench top for the day phase detector: clock, reset, register writes,
// reading stimulus, result back-pressure and the verdict.
// Depends on ltdp_pkg, ltdp_if, the detector RTL and ltdp_phase_checker.
`timescale 1ns / 1ps
module tb;
  import ltdp_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;
  int                    fails;
  int                    pending;
  logic                  quiet;
  int                    stall_left;
  logic [STAMP_W-1:0]    clock_ms;

  ltdp_in_if  in_ch ();
  ltdp_out_if out_ch ();

  light_trend_day_phase_detector_top dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  ltdp_phase_checker checker_i (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_ch(in_ch), .out_ch(out_ch), .fails(fails), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result back-pressure: mostly short stalls, now and then a long one.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic int reading_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic send_reading(input logic ok, input logic [LUX_W-1:0] lux,
                              input logic [STAMP_W-1:0] now);
    logic taken;
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.reading_ok <= ok;
    in_ch.lux        <= lux;
    in_ch.now_ms     <= now;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end
    gap = reading_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender until every result is back, then lets any push still
  // in flight finish before the registers change.
  task automatic wait_idle();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // One day: light ramps up through the triggers and back down, with some
  // ignored readings and the odd jump of the clock.
  task automatic run_day(input int lo, input int hi);
    int lux;
    int r;
    for (int k = 0; k < 70; k++) begin
      lux = (k < 35) ? lo + (hi - lo) * k / 34 : lo + (hi - lo) * (69 - k) / 34;
      lux += $urandom_range(0, 8);
      if (lux > 2097151) lux = 2097151;
      clock_ms += $urandom_range(15000, 40000);
      r = $urandom_range(0, 59);
      if (r < 4) begin
        send_reading(1'b0, LUX_W'($urandom), $urandom);
      end else begin
        if (r == 4) clock_ms = $urandom;
        send_reading(1'b1, LUX_W'(lux), clock_ms);
      end
    end
  endtask

  task automatic run_setting(input int rise, input int sett);
    int lo, hi, thr_lo, thr_hi;
    wait_idle();
    write_reg(REG_SUNRISE, CFG_DATA_W'(rise));
    write_reg(REG_SUNSET, CFG_DATA_W'(sett));
    thr_lo = ((rise < sett) ? rise : sett) * 16 / 10;
    thr_hi = ((rise > sett) ? rise : sett) * 16 / 10;
    lo = thr_lo / 4;
    hi = thr_hi * 3 + 16;
    if (hi > 2097151) hi = 2097151;
    run_day(lo, hi);
  endtask

  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    stall_left = 0;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.reading_ok = 1'b0;
    in_ch.lux = '0;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
    clock_ms = 32'hFFFF_0000;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Tracker still disabled: readings must change nothing.
    send_reading(1'b1, 21'h1FFFFF, 32'h0000_0000);
    send_reading(1'b1, 21'h000000, 32'hFFFF_FFFF);
    send_reading(1'b0, 21'h1FFFFF, 32'hFFFF_FFFF);
    wait_idle();
    write_reg(REG_ENABLE, 1);

    // First average from full-scale readings, across the wrap of the clock.
    for (int i = 0; i < 11; i++) begin
      send_reading(1'b1, 21'h1FFFFF, clock_ms);
      clock_ms += 12000;
    end
    send_reading(1'b0, 21'h1FFFFF, 32'hFFFF_FFFF);
    send_reading(1'b1, 21'h000000, clock_ms + 60000);
    // A stamp behind the newest entry gives a wrapped age and pushes.
    send_reading(1'b1, 21'h000123, clock_ms - 1000);
    clock_ms += 120000;
    for (int i = 0; i < 5; i++) begin
      send_reading(1'b1, LUX_W'(i * 40), clock_ms);
      clock_ms += 60000;
    end

    run_setting(100, 50);
    run_setting(1, 1);
    run_setting(9999, 9999);
    run_setting(0, 16383);
    run_setting($urandom_range(1, 9999), $urandom_range(1, 9999));
    run_setting($urandom_range(1, 9999), $urandom_range(1, 9999));
    run_setting($urandom_range(1, 9999), $urandom_range(1, 9999));

    wait_idle();
    write_reg(REG_ENABLE, 0);
    for (int i = 0; i < 5; i++)
      send_reading($urandom_range(0, 1), LUX_W'($urandom), $urandom);

    wait_idle();
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ltdp_pkg.sv
hdl/ltdp_if.sv
hdl/ltdp_div.sv
hdl/ltdp_mul.sv
hdl/ltdp_win.sv
hdl/light_trend_day_phase_detector_top.sv
tb/ltdp_phase_checker.sv
tb/tb.sv
